// ----- rtl/arp_cache_resolver_macros.svh -----
// Assertion macros for the ARP cache resolver checker.
// No dependencies; included by the checker file.
`ifndef ARP_CACHE_RESOLVER_MACROS_SVH
`define ARP_CACHE_RESOLVER_MACROS_SVH

// check on every clock edge, masked while reset is high
`define ARPC_CHECK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("arp cache resolver check failed");

// check on every clock edge, reset included
`define ARPC_CHECK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("arp cache resolver check failed");

`endif

// ----- rtl/arpc_pkg.sv -----
// Shared types, constants and helper functions of the ARP cache resolver.
// No dependencies; imported by every RTL module of the block except arpc_ram.
package arpc_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int GRP_SIZE      = 8;
   localparam int GRP_LOW_W     = $clog2(GRP_SIZE);
   localparam int NUM_GRP       = (TABLE_ENTRIES + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_W         = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int PAD_ENTRIES   = NUM_GRP * GRP_SIZE;

   localparam int OP_W       = 1;
   localparam int OPCODE_W   = 16;
   localparam int IP_W       = 32;
   localparam int MAC_W      = 48;
   localparam int ACT_W      = 3;
   localparam int OUT_IDX_W  = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 48;

   localparam int SRCH_N    = 3;
   localparam int SRCH_RES  = 0;
   localparam int SRCH_FREE = 1;
   localparam int SRCH_PEND = 2;

   localparam logic [OPCODE_W-1:0] OP_REQUEST = 16'd1;
   localparam logic [OPCODE_W-1:0] OP_REPLY   = 16'd2;
   localparam logic [MAC_W-1:0]    BCAST_MAC  = '1;

   typedef enum logic [1:0] {
      ST_FREE     = 2'd0,
      ST_PENDING  = 2'd1,
      ST_RESOLVED = 2'd2
   } status_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_SEND     = 3'd0,
      ACT_HOLD_REQ = 3'd1,
      ACT_NO_ENTRY = 3'd2,
      ACT_REPLY    = 3'd3,
      ACT_RELEASE  = 3'd4,
      ACT_DROP     = 3'd5
   } act_type;

   typedef enum logic [OP_W-1:0] {
      OPN_LOOKUP = 1'b0,
      OPN_FRAME  = 1'b1
   } opn_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OWN_IP  = 1'b0,
      CSR_OWN_MAC = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_GRP,
      S_SEL,
      S_DEC,
      S_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic cmp;
      logic grp;
      logic sel;
      logic commit;
   } cmd_type;

   function automatic logic [GRP_LOW_W-1:0] first_low(input logic [GRP_SIZE-1:0] v);
      logic [GRP_LOW_W-1:0] r;
      r = '0;
      for (int k = GRP_SIZE - 1; k >= 0; k--) begin
         if (v[k]) begin
            r = GRP_LOW_W'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [GRP_W-1:0] first_grp(input logic [NUM_GRP-1:0] v);
      logic [GRP_W-1:0] r;
      r = '0;
      for (int k = NUM_GRP - 1; k >= 0; k--) begin
         if (v[k]) begin
            r = GRP_W'(k);
         end
      end
      return r;
   endfunction

   function automatic logic [OUT_IDX_W-1:0] out_index(input logic [IDX_W-1:0] idx);
      logic [IDX_W+OUT_IDX_W-1:0] wide;
      wide = (IDX_W + OUT_IDX_W)'(idx);
      return wide[OUT_IDX_W-1:0];
   endfunction

endpackage

// ----- rtl/arp_cache_resolver.sv -----
// Top level of the ARP cache resolver: controller plus datapath.
// Depends on arpc_pkg, arpc_ctrl, arpc_dp (and arpc_ram below it).
//
//   channel   handshake          payload
//   request   start / busy       req_operation, req_arp_opcode, req_target_ip,
//                                req_sender_ip, req_sender_mac
//   response  rsp_valid strobe   rsp_action, rsp_dest_mac, rsp_frame_target_ip,
//                                rsp_entry_index
//   config    csr_we             csr_index, csr_wdata
//
// One response per request, after the start transfer has passed through the match
// pipeline: compare, group encode, group select, table update with MAC RAM read,
// then output. A new request is taken in the response cycle or later in idle, never
// while an earlier one is still in the pipeline. Reset is synchronous; the status
// table is cleared at once. The response is never stalled.
module arp_cache_resolver (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [arpc_pkg::OP_W-1:0]           req_operation,
   input  logic [arpc_pkg::OPCODE_W-1:0]       req_arp_opcode,
   input  logic [arpc_pkg::IP_W-1:0]           req_target_ip,
   input  logic [arpc_pkg::IP_W-1:0]           req_sender_ip,
   input  logic [arpc_pkg::MAC_W-1:0]          req_sender_mac,
   output logic                                rsp_valid,
   output logic [arpc_pkg::ACT_W-1:0]          rsp_action,
   output logic [arpc_pkg::MAC_W-1:0]          rsp_dest_mac,
   output logic [arpc_pkg::IP_W-1:0]           rsp_frame_target_ip,
   output logic [arpc_pkg::OUT_IDX_W-1:0]      rsp_entry_index,
   input  logic                                csr_we,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import arpc_pkg::*;

   cmd_type cmd;

   arpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   arpc_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_operation       (req_operation),
      .req_arp_opcode      (req_arp_opcode),
      .req_target_ip       (req_target_ip),
      .req_sender_ip       (req_sender_ip),
      .req_sender_mac      (req_sender_mac),
      .rsp_action          (rsp_action),
      .rsp_dest_mac        (rsp_dest_mac),
      .rsp_frame_target_ip (rsp_frame_target_ip),
      .rsp_entry_index     (rsp_entry_index)
   );

endmodule

// ----- rtl/arpc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the MAC column of the ARP table.
module arpc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 32
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/arpc_ctrl.sv -----
// Sequencing state machine of the ARP cache resolver.
// Depends on arpc_pkg; drives the datapath command struct.
module arpc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output arpc_pkg::cmd_type cmd
);
   import arpc_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy      = !(state_ff == S_IDLE || state_ff == S_OUT);
      accept    = start && !busy;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.load  = accept;
      state_in  = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            state_in = S_GRP;
         end
         S_GRP: begin
            cmd.grp  = 1'b1;
            state_in = S_SEL;
         end
         S_SEL: begin
            cmd.sel  = 1'b1;
            state_in = S_DEC;
         end
         S_DEC: begin
            cmd.commit = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
            state_in  = accept ? S_CMP : S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/arpc_dp.sv -----
// Datapath of the ARP cache resolver: table, match search, decision, result.
// Depends on arpc_pkg and arpc_ram.
module arpc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  arpc_pkg::cmd_type                   cmd,
   input  logic                                csr_we,
   input  logic [arpc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [arpc_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [arpc_pkg::OP_W-1:0]           req_operation,
   input  logic [arpc_pkg::OPCODE_W-1:0]       req_arp_opcode,
   input  logic [arpc_pkg::IP_W-1:0]           req_target_ip,
   input  logic [arpc_pkg::IP_W-1:0]           req_sender_ip,
   input  logic [arpc_pkg::MAC_W-1:0]          req_sender_mac,
   output logic [arpc_pkg::ACT_W-1:0]          rsp_action,
   output logic [arpc_pkg::MAC_W-1:0]          rsp_dest_mac,
   output logic [arpc_pkg::IP_W-1:0]           rsp_frame_target_ip,
   output logic [arpc_pkg::OUT_IDX_W-1:0]      rsp_entry_index
);
   import arpc_pkg::*;

   logic [IP_W-1:0]     own_ip_ff;
   logic [OP_W-1:0]     op_ff;
   logic [OPCODE_W-1:0] opcode_ff;
   logic [IP_W-1:0]     tip_ff;
   logic [IP_W-1:0]     sip_ff;
   logic [MAC_W-1:0]    smac_ff;
   logic [IP_W-1:0]     key;

   status_type          status_ff   [TABLE_ENTRIES];
   logic [IP_W-1:0]     entry_ip_ff [TABLE_ENTRIES];

   logic                   for_us_ff;
   logic                   for_us_in;
   logic [PAD_ENTRIES-1:0] vec_ff [SRCH_N];
   logic [PAD_ENTRIES-1:0] vec_in [SRCH_N];
   logic [NUM_GRP-1:0]     any_ff [SRCH_N];
   logic [NUM_GRP-1:0]     any_in [SRCH_N];
   logic [GRP_LOW_W-1:0]   low_ff [SRCH_N][NUM_GRP];
   logic [GRP_LOW_W-1:0]   low_in [SRCH_N][NUM_GRP];
   logic [GRP_W-1:0]       grp_pick [SRCH_N];
   logic                   found_ff [SRCH_N];
   logic                   found_in [SRCH_N];
   logic [IDX_W-1:0]       hit_ff [SRCH_N];
   logic [IDX_W-1:0]       hit_in [SRCH_N];

   act_type              act_ff;
   act_type              act_in;
   logic [MAC_W-1:0]     mac_ff;
   logic [MAC_W-1:0]     mac_in;
   logic [IP_W-1:0]      fip_ff;
   logic [IP_W-1:0]      fip_in;
   logic [OUT_IDX_W-1:0] oidx_ff;
   logic [OUT_IDX_W-1:0] oidx_in;

   logic [IDX_W-1:0] sel_idx;
   logic             st_we;
   status_type       st_val;
   logic             ip_we;
   logic             ram_we;
   logic             ram_re;
   logic [MAC_W-1:0] ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff <= '0;
      end else if (csr_we && csr_index == CSR_OWN_IP) begin
         own_ip_ff <= csr_wdata[IP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff     <= req_operation;
         opcode_ff <= req_arp_opcode;
         tip_ff    <= req_target_ip;
         sip_ff    <= req_sender_ip;
         smac_ff   <= req_sender_mac;
      end
   end

   assign key = (op_ff == OPN_LOOKUP) ? tip_ff : sip_ff;

   always_comb begin
      for (int s = 0; s < SRCH_N; s++) begin
         vec_in[s] = '0;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         vec_in[SRCH_RES][i]  = status_ff[i] == ST_RESOLVED && entry_ip_ff[i] == key;
         vec_in[SRCH_FREE][i] = status_ff[i] == ST_FREE;
         vec_in[SRCH_PEND][i] = status_ff[i] == ST_PENDING && entry_ip_ff[i] == key;
      end
      for_us_in = opcode_ff == OP_REQUEST && tip_ff == own_ip_ff;
   end

   always_comb begin
      for (int s = 0; s < SRCH_N; s++) begin
         for (int g = 0; g < NUM_GRP; g++) begin
            any_in[s][g] = |vec_ff[s][g*GRP_SIZE +: GRP_SIZE];
            low_in[s][g] = first_low(vec_ff[s][g*GRP_SIZE +: GRP_SIZE]);
         end
      end
   end

   always_comb begin
      for (int s = 0; s < SRCH_N; s++) begin
         grp_pick[s] = first_grp(any_ff[s]);
         found_in[s] = |any_ff[s];
         hit_in[s]   = IDX_W'({grp_pick[s], low_ff[s][grp_pick[s]]});
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmp) begin
         vec_ff    <= vec_in;
         for_us_ff <= for_us_in;
      end
      if (cmd.grp) begin
         any_ff <= any_in;
         low_ff <= low_in;
      end
      if (cmd.sel) begin
         found_ff <= found_in;
         hit_ff   <= hit_in;
      end
   end

   always_comb begin
      act_in  = ACT_DROP;
      mac_in  = '0;
      fip_in  = '0;
      sel_idx = '0;
      st_we   = 1'b0;
      st_val  = ST_FREE;
      ip_we   = 1'b0;
      ram_we  = 1'b0;
      ram_re  = 1'b0;
      if (op_ff == OPN_LOOKUP) begin
         if (found_ff[SRCH_RES]) begin
            act_in  = ACT_SEND;
            sel_idx = hit_ff[SRCH_RES];
            ram_re  = 1'b1;
         end else if (found_ff[SRCH_FREE]) begin
            act_in  = ACT_HOLD_REQ;
            mac_in  = BCAST_MAC;
            fip_in  = tip_ff;
            sel_idx = hit_ff[SRCH_FREE];
            st_we   = 1'b1;
            st_val  = ST_PENDING;
            ip_we   = 1'b1;
         end else begin
            act_in = ACT_NO_ENTRY;
         end
      end else if (for_us_ff) begin
         act_in = ACT_REPLY;
         mac_in = smac_ff;
         fip_in = sip_ff;
         if (found_ff[SRCH_RES]) begin
            sel_idx = hit_ff[SRCH_RES];
            ram_we  = 1'b1;
         end else if (found_ff[SRCH_FREE]) begin
            sel_idx = hit_ff[SRCH_FREE];
            ram_we  = 1'b1;
            ip_we   = 1'b1;
            st_we   = 1'b1;
            st_val  = ST_RESOLVED;
         end
      end else if (opcode_ff == OP_REPLY && found_ff[SRCH_PEND]) begin
         act_in  = ACT_RELEASE;
         mac_in  = smac_ff;
         sel_idx = hit_ff[SRCH_PEND];
         ram_we  = 1'b1;
         st_we   = 1'b1;
         st_val  = ST_RESOLVED;
      end
      oidx_in = out_index(sel_idx);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            status_ff[i] <= ST_FREE;
         end
      end else if (cmd.commit && st_we) begin
         status_ff[sel_idx] <= st_val;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit && ip_we) begin
         entry_ip_ff[sel_idx] <= key;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         act_ff  <= act_in;
         mac_ff  <= mac_in;
         fip_ff  <= fip_in;
         oidx_ff <= oidx_in;
      end
   end

   arpc_ram #(
      .WIDTH (MAC_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_mac_ram (
      .clock   (clock),
      .wr_en   (cmd.commit && ram_we),
      .wr_addr (sel_idx),
      .wr_data (smac_ff),
      .rd_en   (cmd.commit && ram_re),
      .rd_addr (sel_idx),
      .rd_data (ram_rdata)
   );

   assign rsp_action          = act_ff;
   assign rsp_dest_mac        = (act_ff == ACT_SEND) ? ram_rdata : mac_ff;
   assign rsp_frame_target_ip = fip_ff;
   assign rsp_entry_index     = oidx_ff;

endmodule

// ----- rtl/arpc_checker.sv -----
// Port-level checks of the ARP cache resolver, bound to the top level.
// Depends on arpc_pkg and arp_cache_resolver_macros.svh.
`include "arp_cache_resolver_macros.svh"

module arpc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                rsp_valid,
   input logic [arpc_pkg::ACT_W-1:0]          rsp_action,
   input logic [arpc_pkg::MAC_W-1:0]          rsp_dest_mac,
   input logic [arpc_pkg::IP_W-1:0]           rsp_frame_target_ip,
   input logic [arpc_pkg::OUT_IDX_W-1:0]      rsp_entry_index
);
   import arpc_pkg::*;

   logic drop_rsp;
   logic rest_zero;

   assign drop_rsp  = rsp_valid && (rsp_action == ACT_NO_ENTRY || rsp_action == ACT_DROP);
   assign rest_zero = rsp_dest_mac == '0 && rsp_frame_target_ip == '0 &&
                      rsp_entry_index == '0;

   `ARPC_CHECK(a_rsp_after_start, clock, reset, start && !busy |=> ##4 rsp_valid)
   `ARPC_CHECK(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   `ARPC_CHECK(a_rsp_ready_next, clock, reset, rsp_valid |-> !busy)
   `ARPC_CHECK(a_drop_zero, clock, reset, drop_rsp |-> rest_zero)
   `ARPC_CHECK_ALWAYS(a_reset_idle, clock, $past(reset) |-> !busy && !rsp_valid)

endmodule

bind arp_cache_resolver arpc_checker u_checker (.*);
